FILE: design/qcenc_pkg.sv
package qcenc_pkg;

  // fixed field widths of the ports
  localparam int DATA_W       = 32;
  localparam int GEN_ROW_W    = 3;
  localparam int GEN_SEG_W    = 2;
  localparam int OUT_SEG_W    = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 4;
  localparam int MSG_BLOCKS_W = 4;
  localparam int PAR_BLOCKS_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAR_BLOCKS = 1'b1;

  // configuration reset values
  localparam logic [MSG_BLOCKS_W-1:0] MSG_BLOCKS_RST = 4'd8;
  localparam logic [PAR_BLOCKS_W-1:0] PAR_BLOCKS_RST = 3'd4;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MSG  = 1'b1;

  // result kinds
  localparam logic KIND_SYS = 1'b0;
  localparam logic KIND_PAR = 1'b1;

  // accumulator command from the pipeline control
  typedef struct packed {
    logic step;     // a message bit leaves the read stage
    logic msg_bit;  // value of that bit
    logic clear;    // last parity word enters the output register
  } acc_cmd_t;

endpackage

FILE: design/qcenc_gen_bank.sv
module qcenc_gen_bank #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/qcenc_frame_ctrl.sv
module qcenc_frame_ctrl #(
  parameter int CIRCULANT_SIZE = 32,
  parameter int MSG_BLOCK_MAX = 8,
  parameter int PARITY_BLOCK_MAX = 4,
  localparam int ROW_W = (MSG_BLOCK_MAX > 1) ? $clog2(MSG_BLOCK_MAX) : 1,
  localparam int OFF_W = $clog2(CIRCULANT_SIZE),
  localparam int SEG_W = (PARITY_BLOCK_MAX > 1) ? $clog2(PARITY_BLOCK_MAX) : 1,
  localparam int PBC_W = SEG_W + 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [qcenc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qcenc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 step_i,
  output logic [ROW_W-1:0]                     row_o,
  output logic [OFF_W-1:0]                     off_o,
  output logic                                 frame_end_o,
  output logic [PBC_W-1:0]                     par_blocks_o
);

  import qcenc_pkg::*;

  localparam int MBC_W = ROW_W + 1;

  logic [MSG_BLOCKS_W-1:0] msg_blocks_q;
  logic [PAR_BLOCKS_W-1:0] par_blocks_q;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [OFF_W-1:0]        off_q, off_d;
  logic [MBC_W-1:0]        mb_eff;
  logic [MBC_W-1:0]        row_ext;
  logic                    off_wrap;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_blocks_q <= MSG_BLOCKS_RST;
      par_blocks_q <= PAR_BLOCKS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MSG_BLOCKS) begin
        msg_blocks_q <= cfg_data_i[MSG_BLOCKS_W-1:0];
      end
      if (cfg_idx_i == CFG_PAR_BLOCKS) begin
        par_blocks_q <= cfg_data_i[PAR_BLOCKS_W-1:0];
      end
    end
  end

  // saturate block counts into their legal ranges
  always_comb begin
    if (msg_blocks_q == '0) begin
      mb_eff = MBC_W'(1);
    end else if (int'(msg_blocks_q) > MSG_BLOCK_MAX) begin
      mb_eff = MBC_W'(MSG_BLOCK_MAX);
    end else begin
      mb_eff = MBC_W'(msg_blocks_q);
    end
    if (par_blocks_q == '0) begin
      par_blocks_o = PBC_W'(1);
    end else if (int'(par_blocks_q) > PARITY_BLOCK_MAX) begin
      par_blocks_o = PBC_W'(PARITY_BLOCK_MAX);
    end else begin
      par_blocks_o = PBC_W'(par_blocks_q);
    end
  end

  // end of frame: at or past the last position of the current length
  assign row_ext     = MBC_W'(row_q);
  assign off_wrap    = (off_q == OFF_W'(CIRCULANT_SIZE - 1));
  assign frame_end_o = (row_ext >= mb_eff) ||
                       ((row_ext == mb_eff - MBC_W'(1)) && off_wrap);

  // row block and offset counters
  always_comb begin
    row_d = row_q;
    off_d = off_q;
    if (step_i) begin
      if (frame_end_o) begin
        row_d = '0;
        off_d = '0;
      end else if (off_wrap) begin
        off_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        off_d = off_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      off_q <= '0;
    end else begin
      row_q <= row_d;
      off_q <= off_d;
    end
  end

  assign row_o = row_q;
  assign off_o = off_q;

endmodule

FILE: design/qcenc_parity_acc.sv
module qcenc_parity_acc #(
  parameter int CIRCULANT_SIZE = 32,
  parameter int PARITY_BLOCK_MAX = 4,
  localparam int OFF_W = $clog2(CIRCULANT_SIZE),
  localparam int SEG_W = (PARITY_BLOCK_MAX > 1) ? $clog2(PARITY_BLOCK_MAX) : 1
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  qcenc_pkg::acc_cmd_t                                  cmd_i,
  input  logic [OFF_W-1:0]                                     off_i,
  input  logic [PARITY_BLOCK_MAX-1:0][CIRCULANT_SIZE-1:0]      gen_words_i,
  input  logic [SEG_W-1:0]                                     rd_idx_i,
  output logic [CIRCULANT_SIZE-1:0]                            rd_word_o
);

  import qcenc_pkg::*;

  logic [PARITY_BLOCK_MAX-1:0][CIRCULANT_SIZE-1:0]   acc_q, acc_d;
  logic [PARITY_BLOCK_MAX-1:0][2*CIRCULANT_SIZE-1:0] dbl;

  // rotate each segment word toward higher index and fold it in
  always_comb begin
    acc_d = acc_q;
    for (int s = 0; s < PARITY_BLOCK_MAX; s++) begin
      dbl[s] = {gen_words_i[s], gen_words_i[s]} << off_i;
    end
    if (cmd_i.clear) begin
      acc_d = '0;
    end else if (cmd_i.step && cmd_i.msg_bit) begin
      for (int s = 0; s < PARITY_BLOCK_MAX; s++) begin
        acc_d[s] = acc_q[s] ^ dbl[s][2*CIRCULANT_SIZE-1:CIRCULANT_SIZE];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign rd_word_o = acc_q[rd_idx_i];

endmodule

FILE: design/qc_ldpc_circulant_encoder_unit.sv
// channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o   | op_i gen_row_i gen_segment_i gen_word_i msg_bit_i
// output   | out_valid_o / out_ready_i | kind_o data_o segment_o last_o
// config   | cfg_we_i                  | cfg_idx_i cfg_data_i
//
// A message bit passes the read stage (generator read), then enters the output register
// as its systematic beat and folds into the accumulator; one bit per cycle is sustained
// unless the output stalls. The last bit of a frame is followed by parity_blocks parity
// beats, one per cycle unless the output stalls, during which no new bit moves past the
// read stage. Reset clears the position and the accumulator and sets eight message and
// four parity blocks; the generator memory holds nothing defined until it is loaded.
// A stalled output holds its beat; one more message bit waits in the read stage.
module qc_ldpc_circulant_encoder_unit #(
  parameter int CIRCULANT_SIZE = 32,
  parameter int MSG_BLOCK_MAX = 8,
  parameter int PARITY_BLOCK_MAX = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [qcenc_pkg::GEN_ROW_W-1:0]      gen_row_i,
  input  logic [qcenc_pkg::GEN_SEG_W-1:0]      gen_segment_i,
  input  logic [qcenc_pkg::DATA_W-1:0]         gen_word_i,
  input  logic                                 msg_bit_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 kind_o,
  output logic [qcenc_pkg::DATA_W-1:0]         data_o,
  output logic [qcenc_pkg::OUT_SEG_W-1:0]      segment_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic [qcenc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qcenc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import qcenc_pkg::*;

  localparam int ROW_W = (MSG_BLOCK_MAX > 1) ? $clog2(MSG_BLOCK_MAX) : 1;
  localparam int OFF_W = $clog2(CIRCULANT_SIZE);
  localparam int SEG_W = (PARITY_BLOCK_MAX > 1) ? $clog2(PARITY_BLOCK_MAX) : 1;
  localparam int PBC_W = SEG_W + 1;

  logic                   in_acc, msg_acc, load_acc, row_ok;
  logic [ROW_W-1:0]       cur_row;
  logic [OFF_W-1:0]       cur_off;
  logic                   cur_end;
  logic [PBC_W-1:0]       par_blocks;

  logic [PARITY_BLOCK_MAX-1:0][CIRCULANT_SIZE-1:0] gen_words;
  logic [CIRCULANT_SIZE-1:0] par_word;
  acc_cmd_t               acc_cmd;

  // read stage
  logic                   s1_valid_q;
  logic                   s1_bit_q;
  logic [OFF_W-1:0]       s1_off_q;
  logic                   s1_end_q;

  // parity emission
  logic                   pend_q;
  logic [SEG_W-1:0]       par_idx_q;
  logic [PBC_W-1:0]       pb_q;
  logic                   par_last;

  // output register
  logic                   out_valid_q;
  logic                   kind_q;
  logic [DATA_W-1:0]      data_q;
  logic [OUT_SEG_W-1:0]   seg_q;
  logic                   last_q;

  logic                   out_free, adv, par_load;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = s1_valid_q && out_free && !pend_q;
  assign par_load   = pend_q && out_free;
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign msg_acc    = in_acc && (op_i == OP_MSG);
  assign load_acc   = in_acc && (op_i == OP_LOAD);
  assign row_ok     = int'(gen_row_i) < MSG_BLOCK_MAX;
  assign par_last   = (PBC_W'(par_idx_q) == pb_q - PBC_W'(1));

  // frame position and configuration
  qcenc_frame_ctrl #(
    .CIRCULANT_SIZE  (CIRCULANT_SIZE),
    .MSG_BLOCK_MAX   (MSG_BLOCK_MAX),
    .PARITY_BLOCK_MAX(PARITY_BLOCK_MAX)
  ) u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (msg_acc),
    .row_o       (cur_row),
    .off_o       (cur_off),
    .frame_end_o (cur_end),
    .par_blocks_o(par_blocks)
  );

  // generator memory, one bank per parity segment
  for (genvar s = 0; s < PARITY_BLOCK_MAX; s++) begin : g_bank
    logic bank_we;
    assign bank_we = load_acc && row_ok && (int'(gen_segment_i) == s);
    qcenc_gen_bank #(
      .DEPTH(MSG_BLOCK_MAX),
      .WIDTH(CIRCULANT_SIZE)
    ) u_gen_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we),
      .waddr_i(ROW_W'(gen_row_i)),
      .wdata_i(CIRCULANT_SIZE'(gen_word_i)),
      .re_i   (msg_acc),
      .raddr_i(cur_row),
      .rdata_o(gen_words[s])
    );
  end

  // parity accumulator
  assign acc_cmd.step    = adv;
  assign acc_cmd.msg_bit = s1_bit_q;
  assign acc_cmd.clear   = par_load && par_last;

  qcenc_parity_acc #(
    .CIRCULANT_SIZE  (CIRCULANT_SIZE),
    .PARITY_BLOCK_MAX(PARITY_BLOCK_MAX)
  ) u_parity_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (acc_cmd),
    .off_i      (s1_off_q),
    .gen_words_i(gen_words),
    .rd_idx_i   (par_idx_q),
    .rd_word_o  (par_word)
  );

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (msg_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (msg_acc) begin
      s1_bit_q <= msg_bit_i;
      s1_off_q <= cur_off;
      s1_end_q <= cur_end;
    end
  end

  // parity emission state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      par_idx_q <= '0;
      pb_q      <= '0;
    end else if (adv && s1_end_q) begin
      pend_q    <= 1'b1;
      par_idx_q <= '0;
      pb_q      <= par_blocks;
    end else if (par_load) begin
      if (par_last) begin
        pend_q <= 1'b0;
      end else begin
        par_idx_q <= par_idx_q + SEG_W'(1);
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (par_load || adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (par_load) begin
      kind_q <= KIND_PAR;
      data_q <= DATA_W'(par_word);
      seg_q  <= OUT_SEG_W'(par_idx_q);
      last_q <= par_last;
    end else if (adv) begin
      kind_q <= KIND_SYS;
      data_q <= DATA_W'(s1_bit_q);
      seg_q  <= '0;
      last_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign segment_o   = seg_q;
  assign last_o      = last_q;

endmodule

FILE: tb/tb_qc_ldpc_circulant_encoder_unit.sv
`timescale 1ns / 100ps

module tb_qc_ldpc_circulant_encoder_unit;
  import qcenc_pkg::*;

  localparam int ZC            = 32;
  localparam int MSG_MAX       = 8;
  localparam int PAR_MAX       = 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  // one input beat and one output beat
  typedef struct packed {
    logic                 op;
    logic [GEN_ROW_W-1:0] gen_row;
    logic [GEN_SEG_W-1:0] gen_segment;
    logic [DATA_W-1:0]    gen_word;
    logic                 msg_bit;
  } enc_beat_t;

  typedef struct packed {
    logic                 kind;
    logic [DATA_W-1:0]    data;
    logic [OUT_SEG_W-1:0] segment;
    logic                 last;
  } enc_result_t;

  // encoder state mirror and queue of codeword beats still to come out
  class codeword_tracker;
    logic [DATA_W-1:0]       gen_words [MSG_MAX*PAR_MAX];
    bit                      loaded [MSG_MAX*PAR_MAX];
    logic [DATA_W-1:0]       parity_acc [PAR_MAX];
    int unsigned             bit_pos;
    logic [MSG_BLOCKS_W-1:0] msg_blocks_q;
    logic [PAR_BLOCKS_W-1:0] par_blocks_q;
    enc_result_t             expected_beats [$];
    int unsigned             errors, frames, loads, beats_taken, sys_seen, par_seen;

    function new();
      for (int i = 0; i < MSG_MAX*PAR_MAX; i++) begin
        gen_words[i] = '0;
        loaded[i] = 1'b0;
      end
      for (int s = 0; s < PAR_MAX; s++) parity_acc[s] = '0;
      bit_pos = 0;
      msg_blocks_q = MSG_BLOCKS_RST;
      par_blocks_q = PAR_BLOCKS_RST;
      errors = 0;
      frames = 0;
      loads = 0;
      beats_taken = 0;
      sys_seen = 0;
      par_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MSG_BLOCKS: msg_blocks_q = value[MSG_BLOCKS_W-1:0];
        CFG_PAR_BLOCKS: par_blocks_q = value[PAR_BLOCKS_W-1:0];
        default: ;
      endcase
    endfunction

    // register values saturate into their legal range when used
    function int unsigned frame_bits();
      int unsigned mb;
      mb = 32'(msg_blocks_q);
      if (mb < 1) mb = 1;
      if (mb > MSG_MAX) mb = MSG_MAX;
      return mb * ZC;
    endfunction

    function int unsigned active_segments();
      int unsigned pb;
      pb = 32'(par_blocks_q);
      if (pb < 1) pb = 1;
      if (pb > PAR_MAX) pb = PAR_MAX;
      return pb;
    endfunction

    function int unsigned current_row();
      int unsigned row;
      row = bit_pos / ZC;
      if (row > MSG_MAX - 1) row = MSG_MAX - 1;
      return row;
    endfunction

    function bit row_loaded(int unsigned row);
      bit all_there;
      all_there = 1'b1;
      for (int s = 0; s < PAR_MAX; s++) all_there &= loaded[row*PAR_MAX + s];
      return all_there;
    endfunction

    function logic [DATA_W-1:0] rotate_up(logic [DATA_W-1:0] w, int unsigned off);
      if (off == 0) return w;
      return (w << off) | (w >> (ZC - off));
    endfunction

    // append one beat to the tail of the expected queue
    function void enqueue_result(enc_result_t r);
      expected_beats = {expected_beats, r};
    endfunction

    function void absorb_beat(enc_beat_t b);
      int unsigned len, row, off, pb;
      enc_result_t r;
      beats_taken++;
      if (b.op == OP_LOAD) begin
        gen_words[b.gen_row*PAR_MAX + b.gen_segment] = b.gen_word;
        loaded[b.gen_row*PAR_MAX + b.gen_segment] = 1'b1;
        loads++;
        return;
      end
      len = frame_bits();
      pb = active_segments();
      row = current_row();
      off = bit_pos % ZC;
      // every segment accumulates, even those not emitted
      if (b.msg_bit) begin
        for (int s = 0; s < PAR_MAX; s++)
          parity_acc[s] ^= rotate_up(gen_words[row*PAR_MAX + s], off);
      end
      r.kind = KIND_SYS;
      r.data = '0;
      r.data[0] = b.msg_bit;
      r.segment = '0;
      r.last = 1'b0;
      enqueue_result(r);
      // frame end, also when the length shrank below the position
      if (bit_pos + 1 >= len) begin
        for (int unsigned s = 0; s < pb; s++) begin
          r.kind = KIND_PAR;
          r.data = parity_acc[s];
          r.segment = s[OUT_SEG_W-1:0];
          r.last = (s + 1 == pb);
          enqueue_result(r);
        end
        for (int s = 0; s < PAR_MAX; s++) parity_acc[s] = '0;
        bit_pos = 0;
        frames++;
      end else begin
        bit_pos++;
      end
    endfunction

    function void check_beat(logic kind, logic [DATA_W-1:0] data,
                             logic [OUT_SEG_W-1:0] segment, logic last);
      enc_result_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat: kind %0d data %h segment %0d last %0d",
               kind, data, segment, last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $error("data: expected %h, got %h", want.data, data);
        errors++;
      end
      if (segment !== want.segment) begin
        $error("segment: expected %0d, got %0d", want.segment, segment);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
      if (want.kind == KIND_SYS) sys_seen++;
      else par_seen++;
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   op_i = OP_LOAD;
  logic [GEN_ROW_W-1:0]   gen_row_i = '0;
  logic [GEN_SEG_W-1:0]   gen_segment_i = '0;
  logic [DATA_W-1:0]      gen_word_i = '0;
  logic                   msg_bit_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   kind_o;
  logic [DATA_W-1:0]      data_o;
  logic [OUT_SEG_W-1:0]   segment_o;
  logic                   last_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = CFG_MSG_BLOCKS;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  codeword_tracker tracker;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int unsigned            cycles_run = 0;

  qc_ldpc_circulant_encoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .gen_row_i     (gen_row_i),
    .gen_segment_i (gen_segment_i),
    .gen_word_i    (gen_word_i),
    .msg_bit_i     (msg_bit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .data_o        (data_o),
    .segment_o     (segment_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // output beats checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_beat(kind_o, data_o, segment_o, last_o);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run == CYCLE_LIMIT) begin
      $error("no completion within %0d cycles", CYCLE_LIMIT);
      $display("qc_ldpc_circulant_encoder_unit: mismatch");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input enc_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= b.op;
    gen_row_i     <= b.gen_row;
    gen_segment_i <= b.gen_segment;
    gen_word_i    <= b.gen_word;
    msg_bit_i     <= b.msg_bit;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.absorb_beat(b);
    @(negedge clk_i);
  endtask

  task automatic send_load(input int unsigned row, input int unsigned seg,
                           input logic [DATA_W-1:0] word);
    enc_beat_t b;
    b.op          = OP_LOAD;
    b.gen_row     = row[GEN_ROW_W-1:0];
    b.gen_segment = seg[GEN_SEG_W-1:0];
    b.gen_word    = word;
    b.msg_bit     = 1'($urandom_range(1));
    send_beat(b);
  endtask

  // the row about to be read must be complete in the generator memory
  task automatic send_msg_bit(input logic value);
    enc_beat_t   b;
    int unsigned row;
    row = tracker.current_row();
    if (!tracker.row_loaded(row)) begin
      for (int s = 0; s < PAR_MAX; s++) send_load(row, s, $urandom);
    end
    b.op          = OP_MSG;
    b.gen_row     = GEN_ROW_W'($urandom);
    b.gen_segment = GEN_SEG_W'($urandom);
    b.gen_word    = $urandom;
    b.msg_bit     = value;
    send_beat(b);
  endtask

  // message bits with stray generator loads mixed in
  task automatic run_bits(input int unsigned count, input int unsigned one_pct,
                          input int unsigned noise_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_load($urandom_range(MSG_MAX - 1), $urandom_range(PAR_MAX - 1), $urandom);
      send_msg_bit($urandom_range(99) < one_pct);
    end
  endtask

  // hold input until every expected beat is out and the pipe has drained
  task automatic wait_until_quiet();
    in_valid_i <= 1'b0;
    while (tracker.expected_beats.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    tracker.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    tracker = new();
    send_idle_pct = 25;
    recv_idle_pct = 69;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // out-of-range settings saturate: one block, four segments
    write_reg(CFG_MSG_BLOCKS, 4'd0);
    write_reg(CFG_PAR_BLOCKS, 4'd7);
    send_load(0, 0, 32'h0000_0000);
    send_load(0, 1, 32'hFFFF_FFFF);
    send_load(0, 2, 32'h0000_0001);
    send_load(0, 3, 32'h8000_0000);
    send_load(7, 3, 32'hA5A5_5A5A);
    // one frame, ones at both ends of the block, a reload mid-frame
    for (int k = 0; k < ZC; k++) begin
      if (k == 16) send_load(0, 2, 32'h0001_0000);
      send_msg_bit(k == 0 || k == 1 || k == 17 || k == ZC - 1);
    end

    // two-block frame into the second row, then cut short by a smaller length
    wait_until_quiet();
    send_idle_pct = 69;
    recv_idle_pct = 25;
    write_reg(CFG_MSG_BLOCKS, 4'd2);
    write_reg(CFG_PAR_BLOCKS, 4'd1);
    run_bits(ZC + 1, 50, 0);
    wait_until_quiet();
    write_reg(CFG_MSG_BLOCKS, 4'd1);
    run_bits(1, 100, 0);

    // random settings with back-to-back beats, frame left open
    wait_until_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_MSG_BLOCKS, CFG_DATA_W'($urandom_range(15)));
    write_reg(CFG_PAR_BLOCKS, CFG_DATA_W'($urandom_range(15)));
    run_bits(20, $urandom_range(100), 10);

    wait_until_quiet();
    $display("%0d codewords encoded from %0d input beats, %0d generator words loaded",
             tracker.frames, tracker.beats_taken, tracker.loads);
    $display("%0d systematic and %0d parity beats over saturated, shrunk and random settings",
             tracker.sys_seen, tracker.par_seen);
    if (tracker.errors == 0) begin
      $display("qc_ldpc_circulant_encoder_unit: match");
    end else begin
      $display("qc_ldpc_circulant_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/qcenc_pkg.sv
design/qcenc_gen_bank.sv
design/qcenc_frame_ctrl.sv
design/qcenc_parity_acc.sv
design/qc_ldpc_circulant_encoder_unit.sv
tb/tb_qc_ldpc_circulant_encoder_unit.sv
